### sv/stable_priority_queue_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stable priority queue unit
// Concurrent assertion wrappers that compile to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Checked at every rising clock edge, ignored while reset is high.
`define SPQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("stable priority queue assertion failed");
// Checked at every rising clock edge, including during reset.
`define SPQ_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("stable priority queue assertion failed");
`else
`define SPQ_ASSERT(label, clk, rst, prop)
`define SPQ_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// Stable priority queue package
// Sizes, command and status codes, and the cell control and link types.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

   localparam int CAPACITY = 16;
   localparam int DATA_W   = 32;
   localparam int PRIO_W   = 8;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int ENTRY_COUNT_W = 5;

   typedef enum logic [1:0] {
      CMD_ENQUEUE  = 2'd0,
      CMD_DEQ_HEAD = 2'd1,
      CMD_DEQ_EXACT = 2'd2,
      CMD_DEQ_ATMOST = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_NOMATCH = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   // What every cell of the row does at a clock edge.
   typedef enum logic [1:0] {
      MODE_HOLD       = 2'd0,
      MODE_INSERT     = 2'd1,
      MODE_REMOVE_GE  = 2'd2,
      MODE_REMOVE_ALL = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type              mode;
      logic [DATA_W-1:0]     data;
      logic [PRIO_W-1:0]     prio;
   } cell_cmd_type;

   // What a cell shows its neighbors.
   typedef struct packed {
      logic [DATA_W-1:0]     data;
      logic [PRIO_W-1:0]     prio;
      logic                  gt;
      logic                  match;
   } cell_link_type;

endpackage

`default_nettype wire

### sv/stable_priority_queue_unit.sv
// A result is valid in the cycle after its item is accepted.
// One item per cycle while the input is not stalled; the whole row of cells updates together.
// The input stalls only while a finished result waits on a stalled output.
// Reset clears the entry count and the output valid; slot contents are kept.
// Every command gives exactly one result item.
// ----------------------------------------------------------------------------
// Stable priority queue unit
// Bounded priority queue kept sorted in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stable_priority_queue_unit_assert.svh"

module stable_priority_queue_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [1:0]                     req_cmd,
   input  wire logic signed [spq_pkg::DATA_W-1:0] req_data_in,
   input  wire logic [spq_pkg::PRIO_W-1:0]     req_priority_req,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic signed [spq_pkg::DATA_W-1:0]   rsp_data_out,
   output logic [spq_pkg::ENTRY_COUNT_W-1:0]   rsp_entry_count,
   output logic                                rsp_is_empty
);
   import spq_pkg::*;

   // Entry count and output register. Only the count and the valid flag are reset.
   logic [COUNT_W-1:0]       count_ff;
   logic [COUNT_W-1:0]       count_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   status_type               rsp_status_ff;
   status_type               rsp_status_in;
   logic [DATA_W-1:0]        rsp_data_ff;
   logic [DATA_W-1:0]        rsp_data_in;

   logic                     accept;
   logic                     full;
   logic                     empty;
   logic                     found;
   logic                     head_ok;
   logic [DATA_W-1:0]        hit_data;
   cmd_type                  cmd;
   cell_cmd_type             cell_cmd;

   cell_link_type            links       [CAPACITY];
   cell_link_type            left_links  [CAPACITY];
   cell_link_type            right_links [CAPACITY];
   logic [CAPACITY-1:0]      occupied;
   logic [CAPACITY-1:0]      hit_vec;
   logic [CAPACITY-1:0]      match_vec;

   // The input moves whenever the output register is free or being emptied.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign cmd       = cmd_type'(req_cmd);

   assign full  = (count_ff == COUNT_W'(CAPACITY));
   assign empty = (count_ff == '0);

   // The row of cells. Slot 0 is the head; entries sit in ascending priority,
   // with equal priorities in arrival order. A slot holds an entry when its
   // index is below the count, so the slots themselves need no valid bits.
   for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
      assign occupied[j]  = (count_ff > COUNT_W'(j));
      assign match_vec[j] = links[j].match;

      if (j == 0) begin : g_left_edge
         assign left_links[j] = '0;
      end else begin : g_left_inner
         assign left_links[j] = links[j-1];
      end

      if (j == CAPACITY - 1) begin : g_right_edge
         assign right_links[j] = '0;
      end else begin : g_right_inner
         assign right_links[j] = links[j+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .cmd        (cell_cmd),
         .occupied   (occupied[j]),
         .left_link  (left_links[j]),
         .right_link (right_links[j]),
         .own_link   (links[j]),
         .first_hit  (hit_vec[j])
      );
   end

   // An exact dequeue succeeds if any held entry carries the requested
   // priority; the oldest such entry is marked by a single first-hit flag.
   assign found   = |match_vec;
   assign head_ok = occupied[0] && (links[0].prio <= req_priority_req);

   always_comb begin
      hit_data = '0;
      for (int j = 0; j < CAPACITY; j++) begin
         hit_data = hit_data | (hit_vec[j] ? links[j].data : '0);
      end
   end

   // Command decode: picks the row operation and the result for this item.
   always_comb begin
      cell_cmd.mode = MODE_HOLD;
      cell_cmd.data = req_data_in;
      cell_cmd.prio = req_priority_req;
      count_in      = count_ff;
      rsp_status_in = ST_OK;
      rsp_data_in   = '1;
      if (accept) begin
         unique case (cmd)
            CMD_ENQUEUE: begin
               if (full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  cell_cmd.mode = MODE_INSERT;
                  count_in      = count_ff + COUNT_W'(1);
               end
            end
            CMD_DEQ_HEAD: begin
               if (empty) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  cell_cmd.mode = MODE_REMOVE_ALL;
                  count_in      = count_ff - COUNT_W'(1);
                  rsp_data_in   = links[0].data;
               end
            end
            CMD_DEQ_EXACT: begin
               if (empty) begin
                  rsp_status_in = ST_EMPTY;
               end else if (found) begin
                  cell_cmd.mode = MODE_REMOVE_GE;
                  count_in      = count_ff - COUNT_W'(1);
                  rsp_data_in   = hit_data;
               end else begin
                  rsp_status_in = ST_NOMATCH;
               end
            end
            CMD_DEQ_ATMOST: begin
               if (empty) begin
                  rsp_status_in = ST_EMPTY;
               end else if (head_ok) begin
                  cell_cmd.mode = MODE_REMOVE_ALL;
                  count_in      = count_ff - COUNT_W'(1);
                  rsp_data_in   = links[0].data;
               end else begin
                  rsp_status_in = ST_NOMATCH;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // A result is loaded with its item; it leaves when the output is not stalled.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   // Count and empty flag are read from the count register, which always
   // reflects the state after the last accepted item.
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_data_out    = $signed(rsp_data_ff);
   assign rsp_entry_count = ENTRY_COUNT_W'(count_ff);
   assign rsp_is_empty    = empty;

   `SPQ_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid && (count_ff == '0))
   `SPQ_ASSERT(a_count_bound, clock, reset, count_ff <= COUNT_W'(CAPACITY))
   `SPQ_ASSERT(a_single_hit, clock, reset, $onehot0(hit_vec))
   `SPQ_ASSERT(a_full_drop, clock, reset,
      accept && (cmd == CMD_ENQUEUE) && full |=> rsp_valid && (rsp_status == ST_FULL))
   `SPQ_ASSERT(a_count_idle, clock, reset, !accept |=> $stable(count_ff))

endmodule

`default_nettype wire

### sv/spq_cell.sv
// ----------------------------------------------------------------------------
// Stable priority queue cell
// One slot of the sorted row: holds an entry and moves it left or right.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
   input  wire logic                  clock,
   input  wire spq_pkg::cell_cmd_type cmd,
   input  wire logic                  occupied,
   input  wire spq_pkg::cell_link_type left_link,
   input  wire spq_pkg::cell_link_type right_link,
   output spq_pkg::cell_link_type     own_link,
   output logic                       first_hit
);
   import spq_pkg::*;

   logic [DATA_W-1:0] slot_data_ff;
   logic [DATA_W-1:0] slot_data_in;
   logic [PRIO_W-1:0] slot_prio_ff;
   logic [PRIO_W-1:0] slot_prio_in;
   logic              gt_self;
   logic              ge_self;
   logic              match_self;

   // An empty slot counts as holding a priority beyond every request.
   assign gt_self    = !occupied || (slot_prio_ff > cmd.prio);
   assign ge_self    = !occupied || (slot_prio_ff >= cmd.prio);
   assign match_self = occupied && (slot_prio_ff == cmd.prio);

   always_comb begin
      slot_data_in = slot_data_ff;
      slot_prio_in = slot_prio_ff;
      unique case (cmd.mode)
         MODE_INSERT: begin
            if (gt_self) begin
               if (left_link.gt) begin
                  slot_data_in = left_link.data;
                  slot_prio_in = left_link.prio;
               end else begin
                  slot_data_in = cmd.data;
                  slot_prio_in = cmd.prio;
               end
            end
         end
         MODE_REMOVE_GE: begin
            if (ge_self) begin
               slot_data_in = right_link.data;
               slot_prio_in = right_link.prio;
            end
         end
         MODE_REMOVE_ALL: begin
            slot_data_in = right_link.data;
            slot_prio_in = right_link.prio;
         end
         MODE_HOLD: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      slot_data_ff <= slot_data_in;
      slot_prio_ff <= slot_prio_in;
   end

   assign own_link.data  = slot_data_ff;
   assign own_link.prio  = slot_prio_ff;
   assign own_link.gt    = gt_self;
   assign own_link.match = match_self;

   // Equal priorities sit together, so the oldest match has no match on its left.
   assign first_hit = match_self && !left_link.match;

endmodule

`default_nettype wire

### tb/tb_stable_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the stable priority queue unit
// Drives random and directed commands through the request channel with random
// gaps, stalls the response channel at random, and checks every response item
// against a cycle-free software copy of the sorted queue kept in this module.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_stable_priority_queue_unit;

   import spq_pkg::*;

   // One command waiting to be offered, with the idle time that precedes it.
   typedef struct {
      cmd_type                 cmd;
      logic signed [DATA_W-1:0] data;
      logic [PRIO_W-1:0]       prio;
      int                      gap;
      bit                      drain;   // wait for all responses before offering
   } queue_cmd_type;

   // The response item that one command must produce.
   typedef struct {
      status_type               status;
      logic signed [DATA_W-1:0] data;
      logic [ENTRY_COUNT_W-1:0] count;
      logic                     empty;
   } queue_outcome_type;

   localparam int RANDOM_ITEMS = 1000;
   localparam int HOLD_CYCLES  = 150;
   localparam int HOLD_AT_A    = 120;
   localparam int HOLD_AT_B    = 640;
   localparam int TAIL_CYCLES  = 10;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_cmd = 2'd0;
   logic signed [DATA_W-1:0]  req_data_in = '0;
   logic [PRIO_W-1:0]         req_priority_req = '0;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [1:0]                rsp_status;
   logic signed [DATA_W-1:0]  rsp_data_out;
   logic [ENTRY_COUNT_W-1:0]  rsp_entry_count;
   logic                      rsp_is_empty;

   // The response stall is the union of the per-item random stall and the
   // long hold-off, each owned by its own process.
   logic                      gap_stall  = 1'b0;
   logic                      hold_stall = 1'b0;
   assign rsp_stall = gap_stall | hold_stall;

   stable_priority_queue_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_data_in      (req_data_in),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_data_out     (rsp_data_out),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_is_empty     (rsp_is_empty)
   );

   // -------------------------------------------------------------------------
   // Clock and reset. Reset is held high from the start and released at a
   // falling edge, so the block never sees it change next to a sampling edge.
   // -------------------------------------------------------------------------
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Shadow copy of the queue. Entries sit in ascending priority order from
   // slot 0, and equal priorities keep their arrival order.
   // -------------------------------------------------------------------------
   logic signed [DATA_W-1:0] held_data [CAPACITY];
   logic [PRIO_W-1:0]        held_prio [CAPACITY];
   int                       held_count = 0;

   // Removes the entry at pos, closes the hole, and hands back its payload.
   function automatic logic signed [DATA_W-1:0] take_slot(int pos);
      logic signed [DATA_W-1:0] val;
      val = held_data[pos];
      for (int i = pos; i + 1 < held_count; i++) begin
         held_data[i] = held_data[i + 1];
         held_prio[i] = held_prio[i + 1];
      end
      held_count--;
      return val;
   endfunction

   // Applies one command to the shadow queue and returns the response it owes.
   function automatic queue_outcome_type apply_command(cmd_type cmd,
                                                       logic signed [DATA_W-1:0] din,
                                                       logic [PRIO_W-1:0] prio);
      queue_outcome_type r;
      int pos;
      r.status = ST_OK;
      r.data   = -1;
      if (cmd == CMD_ENQUEUE) begin
         if (held_count >= CAPACITY) begin
            r.status = ST_FULL;
         end else begin
            // The new entry goes behind every entry of equal or lower number.
            pos = 0;
            while (pos < held_count && held_prio[pos] <= prio) pos++;
            for (int i = held_count; i > pos; i--) begin
               held_data[i] = held_data[i - 1];
               held_prio[i] = held_prio[i - 1];
            end
            held_data[pos] = din;
            held_prio[pos] = prio;
            held_count++;
         end
      end else if (held_count == 0) begin
         r.status = ST_EMPTY;
      end else if (cmd == CMD_DEQ_HEAD) begin
         r.data = take_slot(0);
      end else if (cmd == CMD_DEQ_EXACT) begin
         // The oldest entry of that priority is the first one found.
         pos = 0;
         while (pos < held_count && held_prio[pos] != prio) pos++;
         if (pos < held_count) begin
            r.data = take_slot(pos);
         end else begin
            r.status = ST_NOMATCH;
         end
      end else begin
         // Sorted order means only the head can qualify for an at-most limit.
         if (held_prio[0] <= prio) begin
            r.data = take_slot(0);
         end else begin
            r.status = ST_NOMATCH;
         end
      end
      r.count = held_count[ENTRY_COUNT_W-1:0];
      r.empty = (held_count == 0);
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Command list and response bookkeeping.
   // -------------------------------------------------------------------------
   queue_cmd_type     pending_cmds[$];
   queue_outcome_type owed_results[$];

   int  fail_count  = 0;
   int  items_taken = 0;
   int  checked     = 0;
   int  cmd_seen    [4];
   int  status_seen [4];
   bit  req_hs = 1'b0;   // an item was accepted at the last rising edge
   bit  rsp_hs = 1'b0;   // a response was accepted at the last rising edge
   bit  phase_calm = 1'b0;

   function automatic logic [PRIO_W-1:0] pick_prio();
      int roll;
      roll = $urandom_range(0, 9);
      // Mostly a narrow band so that ties and exact matches are common.
      if (roll < 6) return PRIO_W'($urandom_range(0, 7));
      if (roll == 6) return '0;
      if (roll == 7) return '1;
      return PRIO_W'($urandom);
   endfunction

   task automatic push_cmd(cmd_type cmd, logic signed [DATA_W-1:0] data,
                           logic [PRIO_W-1:0] prio, bit drain);
      queue_cmd_type c;
      int idx;
      idx     = pending_cmds.size();
      c.cmd   = cmd;
      c.data  = data;
      c.prio  = prio;
      c.drain = drain;
      // Around the two hold-off points the sender offers back to back, so the
      // block backs up behind the stalled response channel.
      if (phase_calm || (idx >= HOLD_AT_A - 5 && idx < HOLD_AT_A + 80) ||
          (idx >= HOLD_AT_B - 5 && idx < HOLD_AT_B + 80)) begin
         c.gap   = 0;
         c.drain = 1'b0;
      end else begin
         c.gap = $urandom_range(0, 13);
      end
      pending_cmds.push_back(c);
   endtask

   // -------------------------------------------------------------------------
   // Sampling at the rising edge: check the response, then predict for the
   // item accepted at this edge. Its response can come in the following cycle
   // at the earliest, so the order of the two steps never matters.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      queue_outcome_type want;
      req_hs = 1'b0;
      rsp_hs = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_hs = 1'b1;
            if (owed_results.size() == 0) begin
               $error("response item with no command waiting: status %0d data %0d",
                      rsp_status, rsp_data_out);
               fail_count++;
            end else begin
               want = owed_results.pop_front();
               checked++;
               status_seen[want.status]++;
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d actual %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_data_out !== want.data) begin
                  $error("data_out: expected %0d actual %0d", want.data, rsp_data_out);
                  fail_count++;
               end
               if (rsp_entry_count !== want.count) begin
                  $error("entry_count: expected %0d actual %0d", want.count,
                         rsp_entry_count);
                  fail_count++;
               end
               if (rsp_is_empty !== want.empty) begin
                  $error("is_empty: expected %0d actual %0d", want.empty, rsp_is_empty);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            req_hs = 1'b1;
            items_taken++;
            cmd_seen[req_cmd]++;
            owed_results.push_back(apply_command(cmd_type'(req_cmd), req_data_in,
                                                 req_priority_req));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Driver. At each falling edge it retires the item taken at the last rising
   // edge, then works through the next item's pause before offering it. An
   // item with no pause follows its predecessor with valid kept high.
   // -------------------------------------------------------------------------
   queue_cmd_type cur_cmd;
   bit            have_cmd = 1'b0;
   bit            offering = 1'b0;
   int            gap_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (offering && req_hs) begin
            offering = 1'b0;
         end
         if (!offering && !have_cmd && pending_cmds.size() != 0) begin
            cur_cmd  = pending_cmds.pop_front();
            have_cmd = 1'b1;
            gap_left = cur_cmd.gap;
         end
         if (have_cmd && !offering) begin
            if (cur_cmd.drain && owed_results.size() != 0) begin
               // Sender stays quiet until every owed response has been seen.
            end else if (gap_left > 0) begin
               gap_left--;
            end else begin
               offering         = 1'b1;
               have_cmd         = 1'b0;
               req_cmd          <= cur_cmd.cmd;
               req_data_in      <= cur_cmd.data;
               req_priority_req <= cur_cmd.prio;
            end
         end
         req_valid <= offering;
      end
   end

   // -------------------------------------------------------------------------
   // Response stall, per item. After each accepted response a new stall length
   // is drawn; now and then the receiver switches to a stretch with no stall.
   // -------------------------------------------------------------------------
   int stall_left = 0;
   bit rsp_calm   = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         gap_stall <= 1'b0;
      end else begin
         if (rsp_hs) begin
            if ($urandom_range(0, 9) == 0) rsp_calm = ~rsp_calm;
            stall_left = rsp_calm ? 0 : $urandom_range(0, 13);
         end
         gap_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // -------------------------------------------------------------------------
   // Long hold-off. Twice in the run the receiver refuses responses for a long
   // stretch while the sender keeps offering, which backs the block up until
   // it stalls its request channel.
   // -------------------------------------------------------------------------
   int hold_left  = 0;
   int holds_done = 0;

   always @(negedge clock) begin
      if (reset) begin
         hold_stall <= 1'b0;
      end else begin
         if (hold_left == 0 &&
             ((holds_done == 0 && items_taken >= HOLD_AT_A) ||
              (holds_done == 1 && items_taken >= HOLD_AT_B))) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
         end
         hold_stall <= (hold_left > 0);
         if (hold_left > 0) hold_left--;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus and end of run.
   // -------------------------------------------------------------------------
   initial begin
      int kind;
      int len;
      int roll;
      int total;
      cmd_type c;

      // Directed part: every dequeue form on an empty queue, the extreme
      // payloads and priorities, a run of equal priorities to show the queue
      // is stable, a missed exact match, and an at-most limit just below and
      // just at the head priority.
      push_cmd(CMD_DEQ_HEAD,   32'sd0, 8'd0, 1'b0);
      push_cmd(CMD_DEQ_EXACT,  32'sd0, 8'd0, 1'b0);
      push_cmd(CMD_DEQ_ATMOST, -1, 8'd255, 1'b0);
      push_cmd(CMD_ENQUEUE, 32'sh7FFF_FFFF, 8'd255, 1'b0);
      push_cmd(CMD_ENQUEUE, 32'sh8000_0000, 8'd0, 1'b0);
      push_cmd(CMD_ENQUEUE, 32'sd1, 8'd5, 1'b0);
      push_cmd(CMD_ENQUEUE, 32'sd2, 8'd5, 1'b0);
      push_cmd(CMD_ENQUEUE, 32'sd3, 8'd5, 1'b0);
      push_cmd(CMD_ENQUEUE, 32'sh5555_AAAA, 8'd128, 1'b0);
      push_cmd(CMD_ENQUEUE, -1, 8'd5, 1'b0);
      push_cmd(CMD_DEQ_HEAD,   32'sh1234_5678, 8'd77, 1'b0);
      push_cmd(CMD_DEQ_EXACT,  32'sd0, 8'd5, 1'b0);
      push_cmd(CMD_DEQ_EXACT,  32'sd0, 8'd77, 1'b0);
      push_cmd(CMD_DEQ_ATMOST, 32'sd0, 8'd4, 1'b0);
      push_cmd(CMD_DEQ_ATMOST, 32'sd0, 8'd5, 1'b0);
      push_cmd(CMD_DEQ_EXACT,  32'sd0, 8'd255, 1'b0);
      push_cmd(CMD_DEQ_ATMOST, 32'sd0, 8'd255, 1'b1);

      // Random part, in phases. Fill phases always overrun the capacity and
      // drain phases always empty the queue, whatever state they start from.
      total = pending_cmds.size() + RANDOM_ITEMS;
      while (pending_cmds.size() < total) begin
         kind       = $urandom_range(0, 4);
         phase_calm = ($urandom_range(0, 4) == 0);
         len        = (kind == 1 || kind == 2) ? CAPACITY + 4 : $urandom_range(10, 40);
         for (int i = 0; i < len; i++) begin
            roll = $urandom_range(0, 99);
            unique case (kind)
               0: begin
                  c = (roll < 45) ? CMD_ENQUEUE : cmd_type'($urandom_range(1, 3));
               end
               1: begin
                  c = CMD_ENQUEUE;
               end
               2: begin
                  c = (roll < 60) ? CMD_DEQ_HEAD : CMD_DEQ_ATMOST;
               end
               3: begin
                  c = (roll < 50) ? CMD_ENQUEUE : CMD_DEQ_EXACT;
               end
               default: begin
                  c = (roll < 50) ? CMD_ENQUEUE : CMD_DEQ_ATMOST;
               end
            endcase
            if (kind == 2 && c == CMD_DEQ_ATMOST) begin
               push_cmd(c, $urandom, 8'd255, (i == 0) && roll[0]);
            end else if (kind == 3) begin
               push_cmd(c, $urandom, PRIO_W'($urandom_range(0, 4)), 1'b0);
            end else begin
               push_cmd(c, $urandom, pick_prio(), (i == 0) && ($urandom_range(0, 3) == 0));
            end
         end
      end
      phase_calm = 1'b0;

      // Let every item go out, every response come back, and then wait out a quiet
      // tail so that a stray extra response would still be caught.
      @(negedge clock);
      while (reset) @(posedge clock);
      while (pending_cmds.size() != 0 || have_cmd || offering) @(posedge clock);
      while (owed_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (owed_results.size() != 0) begin
         $error("%0d response items never arrived", owed_results.size());
         fail_count++;
      end

      $display("Run covered %0d items: %0d enqueue, %0d head, %0d exact, %0d at-most.",
               items_taken, cmd_seen[CMD_ENQUEUE], cmd_seen[CMD_DEQ_HEAD],
               cmd_seen[CMD_DEQ_EXACT], cmd_seen[CMD_DEQ_ATMOST]);
      $display("Checked %0d responses: %0d ok, %0d empty, %0d no match, %0d full.",
               checked, status_seen[ST_OK], status_seen[ST_EMPTY],
               status_seen[ST_NOMATCH], status_seen[ST_FULL]);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog, set far beyond the slowest legal run of this stimulus.
   initial begin
      #4000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
+incdir+sv
sv/spq_pkg.sv
sv/spq_cell.sv
sv/stable_priority_queue_unit.sv
tb/tb_stable_priority_queue_unit.sv
